@@ hw/rtl/kmvs_pkg.sv @@
package kmvs_pkg;

    // Default capacity of one city set
    localparam int MAX_CITIES_DEF = 32;

    // Field widths
    localparam int COORD_W  = 20;
    localparam int COST_W   = 30;
    localparam int NODE_W   = 6;
    localparam int LINK_W   = 5;
    localparam int DIST_W   = COORD_W + 1;
    localparam int RSUM_W   = COST_W + 1;
    localparam int WEIGHT_W = DIST_W + RSUM_W;
    localparam int KEY_W    = WEIGHT_W + 2 * NODE_W;
    localparam int TOTAL_W  = 59;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TOTAL   = 2'd0,
        KIND_STATION = 2'd1,
        KIND_LINK    = 2'd2
    } t_kind;

    // Controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_FETCH,
        ST_LATCH,
        ST_TOTAL,
        ST_ENEXT,
        ST_ESCAN,
        ST_EDRAIN,
        ST_EMIT,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              run_init;
        logic              scan_issue;
        logic              pick;
        logic              fetch;
        logic              latch_v;
        logic              emit_total;
        logic              class_reset;
        logic              escan_init;
        logic              escan_issue;
        logic              emit_edge;
        logic              sel_link;
        logic              last_item;
        logic              clear_count;
        logic [NODE_W-1:0] node;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [NODE_W-1:0] count;
        logic [NODE_W-1:0] station_cnt;
        logic [NODE_W-1:0] link_cnt;
        logic              busy;
        logic              out_free;
    } t_status;

endpackage

@@ hw/rtl/kmvs_ctrl.sv @@
module kmvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last,
    input  kmvs_pkg::t_status i_status,
    output logic              o_in_stall,
    output kmvs_pkg::t_cmd    o_cmd
);

    kmvs_pkg::t_state r_state, n_state;
    logic [kmvs_pkg::NODE_W-1:0] r_node, n_node;
    logic [kmvs_pkg::NODE_W-1:0] r_round, n_round;
    logic [kmvs_pkg::NODE_W-1:0] r_ecnt, n_ecnt;
    logic                        r_cls, n_cls;
    logic [kmvs_pkg::NODE_W-1:0] ecnt_inc;

    assign ecnt_inc = r_ecnt + kmvs_pkg::NODE_W'(1);

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmvs_pkg::ST_LOAD;
            r_node  <= '0;
            r_round <= '0;
            r_ecnt  <= '0;
            r_cls   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_round <= n_round;
            r_ecnt  <= n_ecnt;
            r_cls   <= n_cls;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        n_round    = r_round;
        n_ecnt     = r_ecnt;
        n_cls      = r_cls;
        o_cmd      = '0;
        o_cmd.node = r_node;
        o_cmd.sel_link = r_cls;
        o_in_stall = 1'b1;
        unique case (r_state)
            kmvs_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last) begin
                    n_state = kmvs_pkg::ST_INIT;
                end
            end
            kmvs_pkg::ST_INIT: begin
                o_cmd.run_init = 1'b1;
                n_round = '0;
                n_node  = kmvs_pkg::NODE_W'(1);
                n_state = kmvs_pkg::ST_SCAN;
            end
            // one city per cycle into the relax pipeline
            kmvs_pkg::ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (r_node == i_status.count) begin
                    n_state = kmvs_pkg::ST_DRAIN;
                end else begin
                    n_node = r_node + kmvs_pkg::NODE_W'(1);
                end
            end
            kmvs_pkg::ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = kmvs_pkg::ST_PICK;
                end
            end
            kmvs_pkg::ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_round = r_round + kmvs_pkg::NODE_W'(1);
                if (n_round == i_status.count) begin
                    n_state = kmvs_pkg::ST_TOTAL;
                end else begin
                    n_state = kmvs_pkg::ST_FETCH;
                end
            end
            kmvs_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = kmvs_pkg::ST_LATCH;
            end
            kmvs_pkg::ST_LATCH: begin
                o_cmd.latch_v = 1'b1;
                n_node  = kmvs_pkg::NODE_W'(1);
                n_state = kmvs_pkg::ST_SCAN;
            end
            kmvs_pkg::ST_TOTAL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_total = 1'b1;
                    n_cls   = 1'b0;
                    n_ecnt  = '0;
                    n_state = kmvs_pkg::ST_ENEXT;
                end
            end
            // pick next class or next edge to emit, or finish once both classes are sent
            kmvs_pkg::ST_ENEXT: begin
                priority if (!r_cls && r_ecnt == i_status.station_cnt) begin
                    o_cmd.class_reset = 1'b1;
                    n_cls  = 1'b1;
                    n_ecnt = '0;
                end else if (r_cls && r_ecnt == i_status.link_cnt) begin
                    n_state = kmvs_pkg::ST_DONE;
                end else begin
                    o_cmd.escan_init = 1'b1;
                    n_node  = kmvs_pkg::NODE_W'(1);
                    n_state = kmvs_pkg::ST_ESCAN;
                end
            end
            kmvs_pkg::ST_ESCAN: begin
                o_cmd.escan_issue = 1'b1;
                if (r_node == i_status.count) begin
                    n_state = kmvs_pkg::ST_EDRAIN;
                end else begin
                    n_node = r_node + kmvs_pkg::NODE_W'(1);
                end
            end
            kmvs_pkg::ST_EDRAIN: begin
                if (!i_status.busy) begin
                    n_state = kmvs_pkg::ST_EMIT;
                end
            end
            kmvs_pkg::ST_EMIT: begin
                o_cmd.last_item = r_cls ? (ecnt_inc == i_status.link_cnt)
                                        : (ecnt_inc == i_status.station_cnt &&
                                           i_status.link_cnt == '0);
                if (i_status.out_free) begin
                    o_cmd.emit_edge = 1'b1;
                    n_ecnt  = ecnt_inc;
                    n_state = kmvs_pkg::ST_ENEXT;
                end
            end
            kmvs_pkg::ST_DONE: begin
                o_cmd.clear_count = 1'b1;
                n_state = kmvs_pkg::ST_LOAD;
            end
            default: begin
                n_state = kmvs_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

@@ hw/rtl/kmvs_datapath.sv @@
module kmvs_datapath #(
    parameter int MAX_CITIES = kmvs_pkg::MAX_CITIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kmvs_pkg::t_cmd               i_cmd,
    output kmvs_pkg::t_status            o_status,
    input  logic [kmvs_pkg::COORD_W-1:0] i_x_coord,
    input  logic [kmvs_pkg::COORD_W-1:0] i_y_coord,
    input  logic [kmvs_pkg::COST_W-1:0]  i_build_cost,
    input  logic [kmvs_pkg::COST_W-1:0]  i_wire_rate,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [kmvs_pkg::TOTAL_W-1:0] o_total_cost,
    output logic [kmvs_pkg::NODE_W-1:0]  o_station_count,
    output logic [kmvs_pkg::LINK_W-1:0]  o_link_count,
    output logic [kmvs_pkg::NODE_W-1:0]  o_node_a,
    output logic [kmvs_pkg::NODE_W-1:0]  o_node_b,
    output logic                         o_last_result
);

    localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int NW = kmvs_pkg::NODE_W;
    localparam int KW = kmvs_pkg::KEY_W;
    localparam int WW = kmvs_pkg::WEIGHT_W;

    // City and per-run stores
    logic [kmvs_pkg::COORD_W-1:0] x_mem    [MAX_CITIES];
    logic [kmvs_pkg::COORD_W-1:0] y_mem    [MAX_CITIES];
    logic [kmvs_pkg::COST_W-1:0]  cost_mem [MAX_CITIES];
    logic [kmvs_pkg::COST_W-1:0]  rate_mem [MAX_CITIES];
    logic [KW-1:0]                best_mem [MAX_CITIES];
    logic [KW-1:0]                chosen_mem [MAX_CITIES];

    logic [NW-1:0] r_count;
    logic [NW-1:0] rd_node, rd_full;
    logic [IDX_W-1:0] rd_addr;

    // registered read data
    logic [kmvs_pkg::COORD_W-1:0] r_rx, r_ry;
    logic [kmvs_pkg::COST_W-1:0]  r_rcost, r_rrate;
    logic [KW-1:0]                r_rbest, r_rchosen;

    // current tree vertex
    logic [kmvs_pkg::COORD_W-1:0] r_vx, r_vy;
    logic [kmvs_pkg::COST_W-1:0]  r_vrate;
    logic [NW-1:0]                r_vid;
    logic                         r_vstation;

    // relax pipeline
    logic          r_s1v, r_s2v, r_s3v;
    logic [NW-1:0] r_s1u, r_s2u, r_s3u;
    logic [kmvs_pkg::DIST_W-1:0] r_s2d;
    logic [kmvs_pkg::RSUM_W-1:0] r_s2rs;
    logic [kmvs_pkg::COST_W-1:0] r_s2cost;
    logic [KW-1:0] r_s2best, r_s3best;
    logic [WW-1:0] r_s3w;

    logic [kmvs_pkg::COORD_W-1:0] dx, dy;
    logic [kmvs_pkg::DIST_W-1:0]  span_sum;
    logic [kmvs_pkg::RSUM_W-1:0]  rsum;
    logic [NW-1:0]  lo, hi;
    logic [KW-1:0]  new_key, nb_key;
    logic [NW-1:0]  s3_full;
    logic [IDX_W-1:0] s3_idx;

    // tree state
    logic [MAX_CITIES-1:0] r_intree;
    logic [KW-1:0] r_min;
    logic          r_minv;
    logic [NW-1:0] r_argmin, am_full;
    logic [NW-1:0] r_nchosen;
    logic [kmvs_pkg::TOTAL_W-1:0] r_total;
    logic [NW-1:0] r_st, r_ln;

    // emission scan
    logic          r_e1v;
    logic [KW-1:0] r_emin, r_prev;
    logic          r_eminv, r_have_prev;
    logic          e_elig;

    // output register
    logic          r_ov;
    kmvs_pkg::t_kind r_okind;
    logic [kmvs_pkg::TOTAL_W-1:0] r_ototal;
    logic [NW-1:0] r_ost, r_oa, r_ob;
    logic [kmvs_pkg::LINK_W-1:0] r_oln;
    logic          r_olast;
    logic          out_free;

    assign rd_node = i_cmd.fetch ? r_argmin : i_cmd.node;
    assign rd_full = rd_node - NW'(1);
    assign rd_addr = rd_full[IDX_W-1:0];
    assign am_full = r_argmin - NW'(1);
    assign s3_full = r_s3u - NW'(1);
    assign s3_idx  = s3_full[IDX_W-1:0];
    assign out_free = !r_ov || !i_out_stall;

    // Load and read ports of the city stores and the per-run key stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < NW'(MAX_CITIES)) begin
            x_mem[r_count[IDX_W-1:0]]    <= i_x_coord;
            y_mem[r_count[IDX_W-1:0]]    <= i_y_coord;
            cost_mem[r_count[IDX_W-1:0]] <= i_build_cost;
            rate_mem[r_count[IDX_W-1:0]] <= i_wire_rate;
        end
        r_rx      <= x_mem[rd_addr];
        r_ry      <= y_mem[rd_addr];
        r_rcost   <= cost_mem[rd_addr];
        r_rrate   <= rate_mem[rd_addr];
        r_rbest   <= best_mem[rd_addr];
        r_rchosen <= chosen_mem[rd_addr];
        if (r_s3v) begin
            best_mem[s3_idx] <= nb_key;
        end
        if (i_cmd.pick) begin
            chosen_mem[r_nchosen[IDX_W-1:0]] <= r_min;
        end
    end

    // Stage 1 math: distance and rate sum
    always_comb begin
        dx       = (r_rx > r_vx) ? r_rx - r_vx : r_vx - r_rx;
        dy       = (r_ry > r_vy) ? r_ry - r_vy : r_vy - r_ry;
        span_sum = {1'b0, dx} + {1'b0, dy};
        rsum     = {1'b0, r_rrate} + {1'b0, r_vrate};
    end

    // Stage 3: edge key and relaxed key
    always_comb begin
        if (r_vstation) begin
            lo = '0;
            hi = r_s3u;
        end else if (r_s3u < r_vid) begin
            lo = r_s3u;
            hi = r_vid;
        end else begin
            lo = r_vid;
            hi = r_s3u;
        end
        new_key = {r_s3w, lo, hi};
        nb_key  = (r_vstation || new_key < r_s3best) ? new_key : r_s3best;
    end

    assign e_elig = ((r_rchosen[2*NW-1:NW] != '0) == i_cmd.sel_link) &&
                    (!r_have_prev || r_rchosen > r_prev);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1v   <= 1'b0;
            r_s2v   <= 1'b0;
            r_s3v   <= 1'b0;
            r_e1v   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.load && r_count < NW'(MAX_CITIES)) begin
                r_count <= r_count + NW'(1);
            end
            r_s1v <= i_cmd.scan_issue;
            r_s2v <= r_s1v;
            r_s3v <= r_s2v;
            r_e1v <= i_cmd.escan_issue;
            if (i_cmd.emit_total || i_cmd.emit_edge) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Relax pipeline, tree growth and emission selection
    always_ff @(posedge i_clk) begin
        r_s1u    <= i_cmd.node;
        r_s2u    <= r_s1u;
        r_s2d    <= span_sum;
        r_s2rs   <= rsum;
        r_s2cost <= r_rcost;
        r_s2best <= r_rbest;
        r_s3u    <= r_s2u;
        r_s3best <= r_s2best;
        r_s3w    <= r_vstation ? WW'(r_s2cost) : r_s2d * r_s2rs;

        if (i_cmd.run_init) begin
            r_vstation <= 1'b1;
            r_minv     <= 1'b0;
            r_intree   <= '0;
            r_nchosen  <= '0;
            r_total    <= '0;
            r_st       <= '0;
            r_ln       <= '0;
        end else begin
            if (r_s3v && !r_intree[s3_idx] && (!r_minv || nb_key < r_min)) begin
                r_min    <= nb_key;
                r_argmin <= r_s3u;
                r_minv   <= 1'b1;
            end
            if (i_cmd.pick) begin
                r_intree[am_full[IDX_W-1:0]] <= 1'b1;
                r_nchosen <= r_nchosen + NW'(1);
                r_total   <= r_total + kmvs_pkg::TOTAL_W'(r_min[KW-1:2*NW]);
                if (r_min[2*NW-1:NW] == '0) begin
                    r_st <= r_st + NW'(1);
                end else begin
                    r_ln <= r_ln + NW'(1);
                end
            end
            if (i_cmd.latch_v) begin
                r_vx       <= r_rx;
                r_vy       <= r_ry;
                r_vrate    <= r_rrate;
                r_vid      <= r_argmin;
                r_vstation <= 1'b0;
                r_minv     <= 1'b0;
            end
        end

        // emission: smallest key of the class above the last one sent
        if (i_cmd.emit_total || i_cmd.class_reset) begin
            r_have_prev <= 1'b0;
        end else if (i_cmd.emit_edge) begin
            r_have_prev <= 1'b1;
            r_prev      <= r_emin;
        end
        if (i_cmd.escan_init) begin
            r_eminv <= 1'b0;
        end else if (r_e1v && e_elig && (!r_eminv || r_rchosen < r_emin)) begin
            r_emin  <= r_rchosen;
            r_eminv <= 1'b1;
        end

        // output payload
        if (i_cmd.emit_total) begin
            r_okind  <= kmvs_pkg::KIND_TOTAL;
            r_ototal <= r_total;
            r_ost    <= r_st;
            r_oln    <= r_ln[kmvs_pkg::LINK_W-1:0];
            r_oa     <= '0;
            r_ob     <= '0;
            r_olast  <= (r_nchosen == '0);
        end else if (i_cmd.emit_edge) begin
            r_okind  <= i_cmd.sel_link ? kmvs_pkg::KIND_LINK : kmvs_pkg::KIND_STATION;
            r_ototal <= '0;
            r_ost    <= '0;
            r_oln    <= '0;
            r_oa     <= i_cmd.sel_link ? r_emin[2*NW-1:NW] : r_emin[NW-1:0];
            r_ob     <= i_cmd.sel_link ? r_emin[NW-1:0] : '0;
            r_olast  <= i_cmd.last_item;
        end
    end

    assign o_status.count       = r_count;
    assign o_status.station_cnt = r_st;
    assign o_status.link_cnt    = r_ln;
    assign o_status.busy        = r_s1v || r_s2v || r_s3v || r_e1v;
    assign o_status.out_free    = out_free;

    assign o_out_valid     = r_ov;
    assign o_kind          = r_okind;
    assign o_total_cost    = r_ototal;
    assign o_station_count = r_ost;
    assign o_link_count    = r_oln;
    assign o_node_a        = r_oa;
    assign o_node_b        = r_ob;
    assign o_last_result   = r_olast;

endmodule

@@ hw/rtl/kruskal_mst_virtual_source_core.sv @@
// Load: one city per cycle, no result until the city with last set.
// Tree build (n cities): one relax pass over all cities per added node
// through a 3-stage distance/multiply/compare pipeline.
// Emission: total record, then each edge after a scan of the chosen edges;
// input stays stalled from the last city until the final result is sent.
// Reset: synchronous active low; clears control, city count and output valid.
module kruskal_mst_virtual_source_core #(
    parameter int MAX_CITIES = kmvs_pkg::MAX_CITIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [kmvs_pkg::COORD_W-1:0] i_x_coord,
    input  logic [kmvs_pkg::COORD_W-1:0] i_y_coord,
    input  logic [kmvs_pkg::COST_W-1:0]  i_build_cost,
    input  logic [kmvs_pkg::COST_W-1:0]  i_wire_rate,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [kmvs_pkg::TOTAL_W-1:0] o_total_cost,
    output logic [kmvs_pkg::NODE_W-1:0]  o_station_count,
    output logic [kmvs_pkg::LINK_W-1:0]  o_link_count,
    output logic [kmvs_pkg::NODE_W-1:0]  o_node_a,
    output logic [kmvs_pkg::NODE_W-1:0]  o_node_b,
    output logic                         o_last_result
);

    kmvs_pkg::t_cmd    cmd;
    kmvs_pkg::t_status status;

    kmvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    kmvs_datapath #(
        .MAX_CITIES (MAX_CITIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_build_cost    (i_build_cost),
        .i_wire_rate     (i_wire_rate),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_total_cost    (o_total_cost),
        .o_station_count (o_station_count),
        .o_link_count    (o_link_count),
        .o_node_a        (o_node_a),
        .o_node_b        (o_node_b),
        .o_last_result   (o_last_result)
    );

endmodule

@@ hw/rtl/kmvs_checker.sv @@
module kmvs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_kind,
    input logic [kmvs_pkg::NODE_W-1:0] o_node_a,
    input logic [kmvs_pkg::NODE_W-1:0] o_node_b
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) &&
        $stable(o_node_a) && $stable(o_node_b))
        else $error("result changed while stalled");

    // total record names no node
    a_total_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == kmvs_pkg::KIND_TOTAL |-> o_node_a == '0 && o_node_b == '0)
        else $error("total record carries nodes");

    // station names one real city
    a_station: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == kmvs_pkg::KIND_STATION |-> o_node_a != '0 && o_node_b == '0)
        else $error("bad station result");

    // link ends are ordered cities
    a_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == kmvs_pkg::KIND_LINK |-> o_node_a != '0 && o_node_a < o_node_b)
        else $error("bad link result");

endmodule

bind kruskal_mst_virtual_source_core kmvs_checker u_kmvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_node_a    (o_node_a),
    .o_node_b    (o_node_b)
);
